FILE: sv/ith_pkg.sv
// ----------------------------------------------------------------------------
// ith_pkg
// Shared types and constants of the in-flight range hazard tracker: action and
// status codes, controller states, and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ith_pkg;

  localparam int SLOTS_DEF       = 16;
  localparam int SECTOR_BITS_DEF = 48;
  localparam int SHIFT_SECTOR    = 9;
  localparam int RACE_BITS       = 32;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_OTHER = 2'd2,
    ACT_DONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_TRACKED = 3'd0,
    ST_PASSED  = 3'd1,
    ST_FULL    = 3'd2,
    ST_FREED   = 3'd3,
    ST_IGNORED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DRAIN,
    FSM_FINISH
  } fsm_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic issue_in;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: sv/ith_ram.sv
// ----------------------------------------------------------------------------
// ith_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ith_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/ith_ctrl.sv
// ----------------------------------------------------------------------------
// ith_ctrl
// Sequencer of the tracker: takes a beat, walks the slot table for an issue,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ith_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ith_pkg::stat_t st,
  output ith_pkg::cmd_t      cmd
);

  ith_pkg::fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ith_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state)
      ith_pkg::FSM_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = st.issue_in ? ith_pkg::FSM_SCAN : ith_pkg::FSM_FINISH;
        end
      end
      ith_pkg::FSM_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) begin
          state_next = ith_pkg::FSM_DRAIN;
        end
      end
      // last read still in flight
      ith_pkg::FSM_DRAIN: begin
        state_next = ith_pkg::FSM_FINISH;
      end
      ith_pkg::FSM_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = ith_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = ith_pkg::FSM_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/ith_datapath.sv
// ----------------------------------------------------------------------------
// ith_datapath
// Slot table, range compare, free-slot search, race counter and output
// register of the tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module ith_datapath #(
  parameter int SLOTS       = ith_pkg::SLOTS_DEF,
  parameter int SECTOR_BITS = ith_pkg::SECTOR_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [1:0]               action,
  input  wire logic [SECTOR_BITS-1:0]   start_sector,
  input  wire logic [31:0]              byte_count,
  input  wire logic [3:0]               done_slot,
  input  wire ith_pkg::cmd_t            cmd,
  output ith_pkg::stat_t                st,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [2:0]                    status,
  output logic                          race_found,
  output logic [3:0]                    given_slot,
  output logic [ith_pkg::RACE_BITS-1:0] races_so_far
);

  localparam int IW  = $clog2(SLOTS);
  localparam int DW  = (IW > 4) ? IW : 4;
  localparam int PW  = SECTOR_BITS + 1;
  localparam int EW  = SECTOR_BITS + PW + 1;

  ith_pkg::action_t        act;
  logic [SECTOR_BITS-1:0]  first;
  logic [PW-1:0]           past_end;
  logic [3:0]              dslot;

  logic [SLOTS-1:0]        slot_valid;
  logic [IW-1:0]           scan_idx;
  logic                    p_live;
  logic                    p_v;
  logic [IW-1:0]           p_idx;
  logic                    hit;
  logic                    free_found;
  logic [IW-1:0]           free_idx;
  logic [ith_pkg::RACE_BITS-1:0] race_total;

  ith_pkg::status_t        stat;
  logic                    race_r;
  logic [3:0]              given_r;

  logic                    ram_we;
  logic [EW-1:0]           ram_wdata;
  logic [EW-1:0]           ram_rdata;
  logic [SECTOR_BITS-1:0]  e_first;
  logic [PW-1:0]           e_past_end;
  logic                    e_mark;
  logic                    wr_op;
  logic                    overlap;
  logic [DW-1:0]           dwide;
  logic [DW-1:0]           fwide;
  logic                    d_ok;
  logic                    is_issue;
  logic                    fin_hit;

  assign is_issue = (act == ith_pkg::ACT_READ) || (act == ith_pkg::ACT_WRITE);
  assign wr_op    = (act == ith_pkg::ACT_WRITE);

  assign {e_first, e_past_end, e_mark} = ram_rdata;
  assign overlap = (PW'(first) < e_past_end) && (past_end > PW'(e_first)) &&
                   (wr_op || e_mark);

  assign dwide = DW'(dslot);
  assign fwide = DW'(free_idx);
  assign d_ok  = (32'(dslot) < 32'(SLOTS)) && slot_valid[dwide[IW-1:0]];

  assign ram_we    = cmd.finish && is_issue && free_found;
  assign ram_wdata = {first, past_end, wr_op};
  assign fin_hit   = hit && free_found;

  ith_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (ram_wdata),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  assign st.issue_in  = (action == ith_pkg::ACT_READ) || (action == ith_pkg::ACT_WRITE);
  assign st.scan_last = (scan_idx == IW'(SLOTS - 1));
  assign st.out_free  = !out_valid || !out_stall;

  // latched beat and derived range
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act      <= ith_pkg::action_t'(action);
      first    <= start_sector;
      past_end <= PW'(start_sector) + PW'(byte_count[31:ith_pkg::SHIFT_SECTOR]);
      dslot    <= done_slot;
    end
  end

  // scan one slot a cycle; table read data comes back in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      p_live <= 1'b0;
    end else begin
      p_live <= cmd.scan_step;
    end
    p_idx <= scan_idx;
    p_v   <= slot_valid[scan_idx];
    if (cmd.load) begin
      scan_idx   <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      free_idx   <= '0;
    end else begin
      if (cmd.scan_step && !st.scan_last) begin
        scan_idx <= scan_idx + IW'(1);
      end
      if (p_live) begin
        if (!p_v && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= p_idx;
        end
        if (p_v && overlap) begin
          hit <= 1'b1;
        end
      end
    end
  end

  // slot state and race counter
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      race_total <= '0;
    end else if (cmd.finish) begin
      if (ram_we) begin
        slot_valid[free_idx] <= 1'b1;
        if (hit && (race_total != '1)) begin
          race_total <= race_total + ith_pkg::RACE_BITS'(1);
        end
      end else if ((act == ith_pkg::ACT_DONE) && d_ok) begin
        slot_valid[dwide[IW-1:0]] <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      race_r  <= 1'b0;
      given_r <= '0;
      unique case (act)
        ith_pkg::ACT_READ, ith_pkg::ACT_WRITE: begin
          if (free_found) begin
            stat    <= ith_pkg::ST_TRACKED;
            race_r  <= fin_hit;
            given_r <= fwide[3:0];
          end else begin
            stat <= ith_pkg::ST_FULL;
          end
        end
        ith_pkg::ACT_OTHER: begin
          stat <= ith_pkg::ST_PASSED;
        end
        ith_pkg::ACT_DONE: begin
          stat <= d_ok ? ith_pkg::ST_FREED : ith_pkg::ST_IGNORED;
        end
        default: begin
          stat <= ith_pkg::ST_PASSED;
        end
      endcase
    end
  end

  assign status       = stat;
  assign race_found   = race_r;
  assign given_slot   = given_r;
  assign races_so_far = race_total;

endmodule

`default_nettype wire

FILE: sv/inflight_range_hazard_tracker.sv
// ----------------------------------------------------------------------------
// inflight_range_hazard_tracker
// Keeps pending block accesses as sector ranges in a slot table and flags
// overlapping accesses where at least one side writes.
// ----------------------------------------------------------------------------
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------
//   in      | in_valid, in_stall  | action, start_sector, byte_count, done_slot
//   out     | out_valid, out_stall| status, race_found, given_slot, races_so_far
//
// an issue beat walks the slot table one slot a cycle through the table ram
// read port, then waits out the last read before its result is registered
// other beats and completions skip the walk and go straight to the result
// rst is synchronous; it empties the table and clears the race count
// the result sits in an output register, so a new beat is taken while it waits;
// a stalled result only holds the tracker at the end of the following beat
// ----------------------------------------------------------------------------
`default_nettype none

module inflight_range_hazard_tracker #(
  parameter int SLOTS       = ith_pkg::SLOTS_DEF,
  parameter int SECTOR_BITS = ith_pkg::SECTOR_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               action,
  input  wire logic [SECTOR_BITS-1:0]   start_sector,
  input  wire logic [31:0]              byte_count,
  input  wire logic [3:0]               done_slot,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [2:0]                    status,
  output logic                          race_found,
  output logic [3:0]                    given_slot,
  output logic [ith_pkg::RACE_BITS-1:0] races_so_far
);

  ith_pkg::cmd_t  cmd;
  ith_pkg::stat_t st;

  ith_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ith_datapath #(
    .SLOTS       (SLOTS),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .action       (action),
    .start_sector (start_sector),
    .byte_count   (byte_count),
    .done_slot    (done_slot),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .race_found   (race_found),
    .given_slot   (given_slot),
    .races_so_far (races_so_far)
  );

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for inflight_range_hazard_tracker. A scoreboard keeps
// its own copy of the slot table and the race count, works out the result of
// every accepted beat and checks the result beats in order. Stimulus starts
// with directed corner cases, then random issue/completion traffic mostly over a
// narrow sector window, with random idling on both sides and one long
// receiver hold.
// ----------------------------------------------------------------------------

localparam int NSLOT = ith_pkg::SLOTS_DEF;
localparam int SBITS = ith_pkg::SECTOR_BITS_DEF;

typedef struct {
  ith_pkg::status_t status;
  bit               race;
  bit [3:0]         slot;
  bit [31:0]        total;
} tracker_result_t;

class tracker_scoreboard;
  bit               slot_busy[NSLOT];
  bit [SBITS-1:0]   range_first[NSLOT];
  bit [SBITS:0]     range_end[NSLOT];
  bit               write_mark[NSLOT];
  bit [31:0]        race_total;
  tracker_result_t  due_q[$];
  int               errors;
  int               checked;
  int               rejected;

  function void note_beat(ith_pkg::action_t act, logic [SBITS-1:0] first, logic [31:0] bytes,
                          logic [3:0] slot);
    tracker_result_t r;
    bit [SBITS:0]    past_end;
    int              free_slot;
    bit              clash;
    r.status = ith_pkg::ST_PASSED;
    r.race   = 0;
    r.slot   = 0;
    if (act == ith_pkg::ACT_READ || act == ith_pkg::ACT_WRITE) begin
      past_end  = {1'b0, first} + (bytes >> ith_pkg::SHIFT_SECTOR);
      free_slot = -1;
      for (int s = NSLOT - 1; s >= 0; s--) if (!slot_busy[s]) free_slot = s;
      if (free_slot < 0) begin
        // full table: rejected before any range check
        r.status = ith_pkg::ST_FULL;
        rejected++;
      end else begin
        clash = 0;
        for (int s = 0; s < NSLOT; s++)
          if (slot_busy[s] && {1'b0, first} < range_end[s] &&
              past_end > {1'b0, range_first[s]} &&
              (act == ith_pkg::ACT_WRITE || write_mark[s]))
            clash = 1;
        if (clash) begin
          r.race = 1;
          if (race_total != 32'hFFFF_FFFF) race_total++;
        end
        slot_busy[free_slot]   = 1;
        range_first[free_slot] = first;
        range_end[free_slot]   = past_end;
        write_mark[free_slot]  = (act == ith_pkg::ACT_WRITE);
        r.status = ith_pkg::ST_TRACKED;
        r.slot   = free_slot[3:0];
      end
    end else if (act == ith_pkg::ACT_DONE) begin
      if (slot < NSLOT && slot_busy[slot]) begin
        slot_busy[slot] = 0;
        r.status = ith_pkg::ST_FREED;
      end else begin
        r.status = ith_pkg::ST_IGNORED;
      end
    end
    r.total = race_total;
    due_q.push_back(r);
  endfunction

  function void check_result(logic [2:0] st, logic race, logic [3:0] slot, logic [31:0] total);
    tracker_result_t r;
    if (due_q.size() == 0) begin
      $display("%0t: result beat with nothing expected (status %0d)", $time, st);
      errors++;
      return;
    end
    r = due_q.pop_front();
    checked++;
    if (st !== r.status) begin
      $display("%0t: status expected %0d got %0d", $time, r.status, st);
      errors++;
    end
    if (race !== r.race) begin
      $display("%0t: race_found expected %0d got %0d", $time, r.race, race);
      errors++;
    end
    if (slot !== r.slot) begin
      $display("%0t: given_slot expected %0d got %0d", $time, r.slot, slot);
      errors++;
    end
    if (total !== r.total) begin
      $display("%0t: races_so_far expected %0d got %0d", $time, r.total, total);
      errors++;
    end
  endfunction

  // random busy slot, or -1 when the table is empty
  function int pick_busy_slot();
    int busy[$];
    for (int s = 0; s < NSLOT; s++) if (slot_busy[s]) busy.push_back(s);
    if (busy.size() == 0) return -1;
    return busy[$urandom_range(0, busy.size() - 1)];
  endfunction

  function int pending();
    return due_q.size();
  endfunction
endclass

module testbench;

  localparam int RANDOM_BEATS = 830;
  localparam int QUIET_TAIL   = 120;
  localparam int HOLD_CYCLES  = 400;

  logic             clk;
  logic             rst          = 1'b1;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic [1:0]       action       = ith_pkg::ACT_OTHER;
  logic [SBITS-1:0] start_sector = '0;
  logic [31:0]      byte_count   = '0;
  logic [3:0]       done_slot    = '0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  logic [2:0]       status;
  logic             race_found;
  logic [3:0]       given_slot;
  logic [31:0]      races_so_far;

  tracker_scoreboard sb = new();
  bit quiet;
  bit hold_now;
  int beats_sent;

  inflight_range_hazard_tracker DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .start_sector (start_sector),
    .byte_count   (byte_count),
    .done_slot    (done_slot),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .race_found   (race_found),
    .given_slot   (given_slot),
    .races_so_far (races_so_far)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // valid stays high between back-to-back beats; gaps lower it
  task automatic send_beat(ith_pkg::action_t act, logic [SBITS-1:0] first, logic [31:0] bytes,
                           logic [3:0] slot);
    in_valid     <= 1'b1;
    action       <= act;
    start_sector <= first;
    byte_count   <= bytes;
    done_slot    <= slot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(act, first, bytes, slot);
    beats_sent++;
  endtask

  task automatic idle_gap(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, race_found, given_slot, races_so_far);
  end

  // receiver: random stall bursts, one long hold, none when quiet
  initial begin
    @(posedge clk);
    forever begin
      if (hold_now) begin
        hold_now = 0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [SBITS-1:0] first;
    logic [31:0]      bytes;
    logic [3:0]       slot;
    ith_pkg::action_t act;
    int               pick;
    int               busy;
    bit               fill_phase;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed corner cases
    send_beat(ith_pkg::ACT_OTHER, '1, '1, 4'hF);
    send_beat(ith_pkg::ACT_DONE, '0, '0, 4'd0);               // empty slot
    send_beat(ith_pkg::ACT_DONE, '0, '0, 4'hF);
    send_beat(ith_pkg::ACT_READ, 48'd100, 32'd4096, '0);      // slot 0: [100,108)
    send_beat(ith_pkg::ACT_READ, 48'd104, 32'd512, '0);       // read over read, no race
    send_beat(ith_pkg::ACT_WRITE, 48'd107, 32'd1024, '0);     // write over read: race
    send_beat(ith_pkg::ACT_WRITE, 48'd108, 32'd0, '0);        // zero length strictly inside
    send_beat(ith_pkg::ACT_READ, 48'd100, 32'd511, '0);       // zero length at a range start
    send_beat(ith_pkg::ACT_WRITE, '1, 32'hFFFF_FFFF, '0);     // range runs past the sector width
    send_beat(ith_pkg::ACT_READ, '1, 32'd511, '0);            // zero length at the start of that write
    send_beat(ith_pkg::ACT_DONE, '0, '0, 4'd2);
    send_beat(ith_pkg::ACT_DONE, '0, '0, 4'd2);               // already freed
    send_beat(ith_pkg::ACT_WRITE, '0, 32'd0, '0);             // reuses lowest free slot
    for (int i = 0; i < 9; i++)
      send_beat(ith_pkg::ACT_READ, 48'd1000 + 48'(i * 16), 32'd512, '0);
    send_beat(ith_pkg::ACT_READ, 48'd2000, 32'd512, '0);      // table full
    send_beat(ith_pkg::ACT_WRITE, 48'd100, 32'd4096, '0);     // full, overlap not counted

    // random traffic in phases of 100 beats
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      fill_phase = ((n / 100) % 2) == 0;
      quiet = ((n / 100) % 3) == 2 || n >= RANDOM_BEATS - QUIET_TAIL;
      if (n == 300) hold_now = 1;
      if (!quiet && $urandom_range(0, 4) == 0) idle_gap($urandom_range(1, 18));

      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        act = ith_pkg::ACT_OTHER;
      end else if (pick < (fill_phase ? 65 : 45)) begin
        act = ($urandom_range(0, 1) != 0) ? ith_pkg::ACT_WRITE : ith_pkg::ACT_READ;
      end else begin
        act = ith_pkg::ACT_DONE;
      end

      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        first = SBITS'($urandom_range(0, 255));
        bytes = $urandom_range(0, 24) * 512 + $urandom_range(0, 511);
      end else if (pick < 88) begin
        first = '1 - SBITS'($urandom_range(0, 64));
        bytes = $urandom;
      end else begin
        first = SBITS'({$urandom, $urandom});
        bytes = $urandom;
      end

      busy = sb.pick_busy_slot();
      if (busy >= 0 && $urandom_range(0, 99) < 85) slot = busy[3:0];
      else slot = 4'($urandom_range(0, 15));

      send_beat(act, first, bytes, slot);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * NSLOT) @(posedge clk);

    $display("%0d beats sent, %0d results checked", beats_sent, sb.checked);
    $display("%0d races counted, %0d issues rejected on a full table",
             sb.race_total, sb.rejected);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ith_pkg.sv
sv/ith_ram.sv
sv/ith_ctrl.sv
sv/ith_datapath.sv
sv/inflight_range_hazard_tracker.sv
verif/testbench.sv
